// ===== rtl/core/vgcs_pkg.sv =====
// ----------------------------------------------------------------------------
// vgcs_pkg
// Shared widths, codes, stage payload types and helpers for the velocity
// grid conservative stencil unit.
// ----------------------------------------------------------------------------
package vgcs_pkg;

  localparam int unsigned VEL_W      = 32;
  localparam int unsigned LIM_W      = 7;
  localparam int unsigned BETA_W     = 24;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 24;
  localparam int unsigned WEIGHT_W   = 32;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned NPTS       = 7;

  localparam int unsigned DEF_INDEX_BITS = 8;

  localparam int unsigned VN_W   = 57;  // scaled velocity, Q.32
  localparam int unsigned ORG_W  = 9;   // origin index, covers +-128
  localparam int unsigned D_W    = 39;  // offset, Q.32, clamped to +-32
  localparam int unsigned A_W    = 31;  // offset, Q.24
  localparam int unsigned SQ_W   = 60;
  localparam int unsigned SUM_W  = 33;
  localparam int unsigned Q_W    = 62;
  localparam int unsigned U_W    = 27;
  localparam int unsigned PROD_W = 59;
  localparam int unsigned FL_W   = 38;
  localparam int unsigned RW_W   = 40;

  localparam logic [LIM_W-1:0]  LIMIT_RESET = 7'd8;
  localparam logic [BETA_W-1:0] BETA_RESET  = 24'd65536;

  localparam logic signed [VN_W-1:0] OVER_CAP = {{(VN_W-38){1'b0}}, 1'b1, 37'b0};
  localparam logic signed [Q_W-1:0]  ONE_Q48  = {{(Q_W-49){1'b0}}, 1'b1, 48'b0};
  localparam logic [U_W-1:0]         U_OFS    = 27'd50331648;   // 3 * 2^24
  localparam logic [31:0]            RECIP3   = 32'hAAAA_AAAB;  // (2^33 + 1) / 3
  localparam logic [FL_W-1:0]        FL_OFS   = 38'd16777216;   // 2^24
  localparam logic [24:0]            HALF_Q25 = 25'h100_0000;

  localparam logic [1:0] STEP_P = 2'b01;
  localparam logic [1:0] STEP_N = 2'b11;
  localparam logic [1:0] STEP_Z = 2'b00;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_BOUND  = 2'd1,
    ST_CORNER = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LIMIT = 1'b0,
    CFG_BETA  = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [2:0][A_W-1:0]   a;
    logic [2:0][ORG_W-1:0] org;
    logic [2:0][1:0]       step;
    logic                  all_in;
    logic [1:0]            ext;
    status_e               status;
  } front_t;

  typedef struct packed {
    logic [NPTS-1:0][WEIGHT_W-1:0] w;
    logic [2:0][ORG_W-1:0]         org;
    logic [2:0][1:0]               step;
    logic [NPTS-1:0]               mask;
    status_e                       status;
  } emit_t;

  function automatic logic [WEIGHT_W-1:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'h7FFF_FFFF;
    end else if (v < -64'sd2147483648) begin
      return 32'h8000_0000;
    end
    return v[WEIGHT_W-1:0];
  endfunction

endpackage

// ===== rtl/core/vgcs_front.sv =====
// ----------------------------------------------------------------------------
// vgcs_front
// Velocity scaling, per-axis classification and offset rounding to Q.24.
// Three register stages.
// ----------------------------------------------------------------------------
module vgcs_front (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic [vgcs_pkg::LIM_W-1:0]             limit_i,
  input  logic [vgcs_pkg::BETA_W-1:0]            beta_i,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic [2:0][vgcs_pkg::VEL_W-1:0]        vel_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output vgcs_pkg::front_t                       out_o
);

  localparam int unsigned VN_W  = vgcs_pkg::VN_W;
  localparam int unsigned ORG_W = vgcs_pkg::ORG_W;
  localparam int unsigned D_W   = vgcs_pkg::D_W;
  localparam int unsigned A_W   = vgcs_pkg::A_W;

  logic v1_q, v2_q, v3_q;
  logic r1, r2, r3;

  logic signed [VN_W-1:0]  vn_d [3];
  logic signed [VN_W-1:0]  vn_q [3];
  logic signed [VN_W-1:0]  limq;
  logic signed [VN_W-1:0]  dout [3];
  logic signed [VN_W-1:0]  dcl [3];
  logic [VN_W-33:0]        hi [3];
  logic [31:0]             frac [3];
  logic                    up [3];
  logic [ORG_W-1:0]        lim9;
  logic [2:0]              outer_d, outer_q;
  logic signed [ORG_W-1:0] org_d [3];
  logic signed [ORG_W-1:0] org_q [3];
  logic signed [D_W-1:0]   d_d [3];
  logic signed [D_W-1:0]   d_q [3];
  logic [1:0]              step_d [3];
  logic [1:0]              step_q [3];

  logic signed [D_W-1:0]   t [3];
  logic [7:0]              rb [3];
  logic [2:0]              at_lim;
  logic [1:0]              cnt;
  vgcs_pkg::front_t        f_d, f_q;

  assign r3         = !v3_q || out_ready_i;
  assign r2         = !v2_q || r3;
  assign r1         = !v1_q || r2;
  assign in_ready_o = r1;

  // stage 1: scale
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      vn_d[k] = VN_W'($signed(vel_i[k])) * VN_W'($signed({1'b0, beta_i}));
    end
  end

  // stage 2: classify axes
  assign limq = VN_W'({limit_i, 32'b0});
  assign lim9 = {{(ORG_W-vgcs_pkg::LIM_W){1'b0}}, limit_i};

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      outer_d[k] = (vn_q[k] >= limq) || (vn_q[k] <= -limq);
      dout[k]    = vn_q[k][VN_W-1] ? vn_q[k] + limq : vn_q[k] - limq;
      if (dout[k] > vgcs_pkg::OVER_CAP) begin
        dcl[k] = vgcs_pkg::OVER_CAP;
      end else if (dout[k] < -vgcs_pkg::OVER_CAP) begin
        dcl[k] = -vgcs_pkg::OVER_CAP;
      end else begin
        dcl[k] = dout[k];
      end
      hi[k]   = vn_q[k][VN_W-1:32];
      frac[k] = vn_q[k][31:0];
      up[k]   = (frac[k] > 32'h8000_0000) || (frac[k] == 32'h8000_0000 && hi[k][0]);
      if (outer_d[k]) begin
        org_d[k] = vn_q[k][VN_W-1] ? -lim9 : lim9;
        d_d[k]   = D_W'(dcl[k]);
        if (d_d[k] > 0) begin
          step_d[k] = vgcs_pkg::STEP_N;
        end else if (d_d[k] < 0) begin
          step_d[k] = vgcs_pkg::STEP_P;
        end else begin
          step_d[k] = vgcs_pkg::STEP_Z;
        end
      end else begin
        org_d[k] = hi[k][ORG_W-1:0] + ORG_W'(up[k]);
        d_d[k]   = D_W'($signed({up[k], frac[k]}));
        if (d_d[k] > 0) begin
          step_d[k] = vgcs_pkg::STEP_P;
        end else if (d_d[k] < 0) begin
          step_d[k] = vgcs_pkg::STEP_N;
        end else begin
          step_d[k] = vgcs_pkg::STEP_Z;
        end
      end
    end
  end

  // stage 3: round offsets, case selection
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      t[k]         = d_q[k] >>> 8;
      rb[k]        = d_q[k][7:0];
      f_d.a[k]     = A_W'(t[k]) + A_W'((rb[k] > 8'h80) || (rb[k] == 8'h80 && t[k][0]));
      f_d.org[k]   = org_q[k];
      f_d.step[k]  = step_q[k];
      at_lim[k]    = (org_q[k] == lim9) || (org_q[k] == -lim9);
    end
    cnt        = 2'(outer_q[0]) + 2'(outer_q[1]) + 2'(outer_q[2]);
    f_d.all_in = (cnt == 2'd0);
    f_d.ext    = 2'd0;
    if (cnt == 2'd1) begin
      if (outer_q[0]) begin
        f_d.ext = 2'd1;
      end else if (outer_q[1]) begin
        f_d.ext = 2'd2;
      end
    end else if (cnt == 2'd2) begin
      if (!outer_q[1]) begin
        f_d.ext = 2'd1;
      end else if (!outer_q[2]) begin
        f_d.ext = 2'd2;
      end
    end
    if (cnt == 2'd3) begin
      f_d.status = vgcs_pkg::ST_CORNER;
    end else if (cnt == 2'd0 && (|at_lim)) begin
      f_d.status = vgcs_pkg::ST_BOUND;
    end else if (cnt != 2'd0 && (&at_lim)) begin
      f_d.status = vgcs_pkg::ST_CORNER;
    end else begin
      f_d.status = vgcs_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (r1) v1_q <= in_valid_i;
      if (r2) v2_q <= v1_q;
      if (r3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (r1) vn_q <= vn_d;
    if (r2) begin
      outer_q <= outer_d;
      org_q   <= org_d;
      d_q     <= d_d;
      step_q  <= step_d;
    end
    if (r3) f_q <= f_d;
  end

  assign out_valid_o = v3_q;
  assign out_o       = f_q;

endmodule

// ===== rtl/core/vgcs_weight.sv =====
// ----------------------------------------------------------------------------
// vgcs_weight
// Squares, correction term, exact division with half-even rounding and the
// saturated point weights. Five register stages.
// ----------------------------------------------------------------------------
module vgcs_weight (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  vgcs_pkg::front_t in_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output vgcs_pkg::emit_t  out_o
);

  localparam int unsigned A_W    = vgcs_pkg::A_W;
  localparam int unsigned SQ_W   = vgcs_pkg::SQ_W;
  localparam int unsigned SUM_W  = vgcs_pkg::SUM_W;
  localparam int unsigned Q_W    = vgcs_pkg::Q_W;
  localparam int unsigned U_W    = vgcs_pkg::U_W;
  localparam int unsigned PROD_W = vgcs_pkg::PROD_W;
  localparam int unsigned FL_W   = vgcs_pkg::FL_W;
  localparam int unsigned RW_W   = vgcs_pkg::RW_W;
  localparam int unsigned WW     = vgcs_pkg::WEIGHT_W;

  logic [4:0] v_q;
  logic [4:0] rdy;

  // stage 1
  logic signed [2*A_W-1:0] ae [3];
  logic signed [2*A_W-1:0] pr [3];
  logic [SQ_W-1:0]         sq_d [3];
  logic [SQ_W-1:0]         sq_q [3];
  logic signed [SUM_W-1:0] suma_d, suma_q;
  vgcs_pkg::front_t        f1_q, f2_q, f3_q, f4_q;

  // stage 2
  logic signed [Q_W-1:0]   s2;
  logic signed [Q_W-1:0]   q_d, q_q, nfo_d, nfo_q;

  // stage 3
  logic signed [Q_W-1:0]   tfo, hiq;
  logic [23:0]             rfo;
  logic                    fo_up;
  logic [WW-1:0]           fo_d, fo3_q, fo4_q;
  logic [U_W-1:0]          u_d, u_q;
  logic [PROD_W-1:0]       p_d, p_q;
  logic [FL_W-1:0]         flo_d, flo_q;
  logic [24:0]             qlo_d, qlo_q;

  // stage 4
  logic [PROD_W-34:0]      q3;
  logic [U_W-1:0]          mfull;
  logic [1:0]              m3;
  logic [FL_W-1:0]         fl_d, fl_q;
  logic                    above_d, above_q, tie_d, tie_q;

  // stage 5
  vgcs_pkg::emit_t         e_d, e_q;
  logic [WW-1:0]           fext;

  function automatic logic [WW-1:0] rnd_w(input logic signed [A_W-1:0] x,
                                          input logic signed [FL_W-1:0] fl,
                                          input logic above,
                                          input logic tie);
    logic signed [RW_W-1:0] s;
    logic signed [RW_W-1:0] r;
    s = RW_W'(x) + RW_W'(fl);
    r = s + RW_W'(above || (tie && s[0]));
    return vgcs_pkg::sat32(64'(r));
  endfunction

  always_comb begin
    rdy[4] = !v_q[4] || out_ready_i;
    for (int i = 3; i >= 0; i--) begin
      rdy[i] = !v_q[i] || rdy[i+1];
    end
  end
  assign in_ready_o = rdy[0];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ae[k]   = (2*A_W)'($signed(in_i.a[k]));
      pr[k]   = ae[k] * ae[k];
      sq_d[k] = pr[k][SQ_W-1:0];
    end
    suma_d = SUM_W'($signed(in_i.a[0])) + SUM_W'($signed(in_i.a[1]))
           + SUM_W'($signed(in_i.a[2]));
  end

  always_comb begin
    s2    = Q_W'(sq_q[0]) + Q_W'(sq_q[1]) + Q_W'(sq_q[2]);
    q_d   = s2 - (Q_W'(suma_q) <<< 24);
    nfo_d = vgcs_pkg::ONE_Q48 - s2;
  end

  always_comb begin
    tfo   = nfo_q >>> 24;
    rfo   = nfo_q[23:0];
    fo_up = (rfo > 24'h80_0000) || (rfo == 24'h80_0000 && tfo[0]);
    fo_d  = vgcs_pkg::sat32(64'(tfo) + 64'(fo_up));
    hiq   = q_q >>> 25;
    u_d   = hiq[U_W-1:0] + vgcs_pkg::U_OFS;
    p_d   = PROD_W'(u_d) * PROD_W'(vgcs_pkg::RECIP3);
    flo_d = hiq[FL_W-1:0];
    qlo_d = q_q[24:0];
  end

  always_comb begin
    q3    = p_q[PROD_W-1:33];
    mfull = u_q - U_W'(q3) - U_W'({q3, 1'b0});
    m3    = mfull[1:0];
    if (f3_q.all_in) begin
      fl_d    = FL_W'(q3) - vgcs_pkg::FL_OFS;
      above_d = (m3 == 2'd2) || (m3 == 2'd1 && qlo_q > vgcs_pkg::HALF_Q25);
      tie_d   = (m3 == 2'd1) && (qlo_q == vgcs_pkg::HALF_Q25);
    end else begin
      fl_d    = flo_q;
      above_d = qlo_q > vgcs_pkg::HALF_Q25;
      tie_d   = qlo_q == vgcs_pkg::HALF_Q25;
    end
  end

  always_comb begin
    fext     = rnd_w('0, $signed(fl_q), above_q, tie_q);
    e_d.org  = f4_q.org;
    e_d.step = f4_q.step;
    e_d.status = f4_q.status;
    e_d.w[0]   = fo4_q;
    e_d.mask[0] = 1'b1;
    for (int k = 0; k < 3; k++) begin
      if (f4_q.all_in || f4_q.ext == 2'(k)) begin
        e_d.w[k+1] = rnd_w($signed(f4_q.a[k]), $signed(fl_q), above_q, tie_q);
      end else begin
        e_d.w[k+1] = WW'($signed(f4_q.a[k]));
      end
      e_d.w[k+4]    = fext;
      e_d.mask[k+1] = f4_q.step[k] != vgcs_pkg::STEP_Z;
      e_d.mask[k+4] = (f4_q.step[k] != vgcs_pkg::STEP_Z)
                      && (f4_q.all_in || f4_q.ext == 2'(k));
    end
    if (f4_q.status != vgcs_pkg::ST_OK) begin
      e_d.mask = {{(vgcs_pkg::NPTS-1){1'b0}}, 1'b1};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= in_valid_i;
      for (int i = 1; i < 5; i++) begin
        if (rdy[i]) v_q[i] <= v_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      sq_q   <= sq_d;
      suma_q <= suma_d;
      f1_q   <= in_i;
    end
    if (rdy[1]) begin
      q_q   <= q_d;
      nfo_q <= nfo_d;
      f2_q  <= f1_q;
    end
    if (rdy[2]) begin
      fo3_q <= fo_d;
      u_q   <= u_d;
      p_q   <= p_d;
      flo_q <= flo_d;
      qlo_q <= qlo_d;
      f3_q  <= f2_q;
    end
    if (rdy[3]) begin
      fl_q    <= fl_d;
      above_q <= above_d;
      tie_q   <= tie_d;
      fo4_q   <= fo3_q;
      f4_q    <= f3_q;
    end
    if (rdy[4]) e_q <= e_d;
  end

  assign out_valid_o = v_q[4];
  assign out_o       = e_q;

endmodule

// ===== rtl/core/vgcs_emit.sv =====
// ----------------------------------------------------------------------------
// vgcs_emit
// Holds one item's stencil and sends its surviving points one beat at a
// time through the output register.
// ----------------------------------------------------------------------------
module vgcs_emit #(
  parameter int unsigned INDEX_BITS = vgcs_pkg::DEF_INDEX_BITS
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  vgcs_pkg::emit_t                      in_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [2:0][INDEX_BITS-1:0]           grid_o,
  output logic [vgcs_pkg::WEIGHT_W-1:0]        weight_o,
  output vgcs_pkg::status_e                    status_o,
  output logic                                 last_o
);

  localparam int unsigned NPTS  = vgcs_pkg::NPTS;
  localparam int unsigned ORG_W = vgcs_pkg::ORG_W;
  localparam int unsigned IDX_W = $clog2(NPTS);

  logic                    buf_vld_q;
  vgcs_pkg::emit_t         buf_q;
  logic [NPTS-1:0]         rem_q, rem_next;
  logic [IDX_W-1:0]        idx;
  logic                    out_free, fire, buf_done;
  logic [1:0]              dl [3];
  logic signed [ORG_W-1:0] coord [3];

  logic                           out_valid_q;
  logic [2:0][INDEX_BITS-1:0]     grid_d, grid_q;
  logic [vgcs_pkg::WEIGHT_W-1:0]  weight_d, weight_q;
  vgcs_pkg::status_e              status_q;
  logic                           last_q;

  always_comb begin
    idx = '0;
    for (int i = NPTS - 1; i >= 0; i--) begin
      if (rem_q[i]) idx = IDX_W'(i);
    end
  end

  assign rem_next   = rem_q & ~(NPTS'(1) << idx);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign fire       = buf_vld_q && out_free;
  assign buf_done   = fire && (rem_next == '0);
  assign in_ready_o = !buf_vld_q || buf_done;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      if (idx == IDX_W'(j + 1)) begin
        dl[j] = buf_q.step[j];
      end else if (idx == IDX_W'(j + 4)) begin
        dl[j] = -buf_q.step[j];
      end else begin
        dl[j] = vgcs_pkg::STEP_Z;
      end
      coord[j]  = $signed(buf_q.org[j]) + ORG_W'($signed(dl[j]));
      grid_d[j] = INDEX_BITS'(coord[j]);
    end
    weight_d = buf_q.w[idx];
    if (buf_q.status != vgcs_pkg::ST_OK) begin
      grid_d   = '0;
      weight_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        buf_vld_q <= in_valid_i;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o) begin
      buf_q <= in_i;
      rem_q <= in_i.mask;
    end else if (fire) begin
      rem_q <= rem_next;
    end
    if (fire) begin
      grid_q   <= grid_d;
      weight_q <= weight_d;
      status_q <= buf_q.status;
      last_q   <= (rem_next == '0);
    end
  end

  assign out_valid_o = out_valid_q;
  assign grid_o      = grid_q;
  assign weight_o    = weight_q;
  assign status_o    = status_q;
  assign last_o      = last_q;

endmodule

// ===== rtl/core/velocity_grid_conservative_stencil_unit.sv =====
// ----------------------------------------------------------------------------
// velocity_grid_conservative_stencil_unit
// Spreads a scaled particle velocity over a seven- or five-point stencil of
// a bounded velocity grid and sends one beat per surviving grid point.
//
//   channel  handshake            payload
//   cfg      cfg_valid/cfg_ready  cfg_index, cfg_data
//   in       in_valid/in_stall    vel_x, vel_y, vel_z
//   out      out_valid/out_stall  grid_x/y/z, weight, status, last
//
// Ten register stages from input beat to the first output beat.
// An item then occupies the output for one beat per point sent (1 to 7),
// set by the single result port; the pipeline keeps filling behind it.
// Asynchronous active-low reset clears valids and loads the limit and beta defaults.
// A stall on out holds the output register and backs up through every stage.
// ----------------------------------------------------------------------------
module velocity_grid_conservative_stencil_unit #(
  parameter int unsigned INDEX_BITS = vgcs_pkg::DEF_INDEX_BITS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [vgcs_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [vgcs_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [vgcs_pkg::VEL_W-1:0] vel_x_i,
  input  logic signed [vgcs_pkg::VEL_W-1:0] vel_y_i,
  input  logic signed [vgcs_pkg::VEL_W-1:0] vel_z_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [INDEX_BITS-1:0]      grid_x_o,
  output logic signed [INDEX_BITS-1:0]      grid_y_o,
  output logic signed [INDEX_BITS-1:0]      grid_z_o,
  output logic signed [vgcs_pkg::WEIGHT_W-1:0] weight_o,
  output logic [vgcs_pkg::STATUS_W-1:0]     status_o,
  output logic                              last_o
);

  logic [vgcs_pkg::LIM_W-1:0]      limit_q;
  logic [vgcs_pkg::BETA_W-1:0]     beta_q;
  logic                            in_ready;
  logic [2:0][vgcs_pkg::VEL_W-1:0] vel;
  logic                            fr_valid, fr_ready;
  vgcs_pkg::front_t                fr;
  logic                            wt_valid, wt_ready;
  vgcs_pkg::emit_t                 wt;
  logic [2:0][INDEX_BITS-1:0]      grid;
  vgcs_pkg::status_e               status;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= vgcs_pkg::LIMIT_RESET;
      beta_q  <= vgcs_pkg::BETA_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (vgcs_pkg::cfg_idx_e'(cfg_index_i))
        vgcs_pkg::CFG_LIMIT: limit_q <= cfg_data_i[vgcs_pkg::LIM_W-1:0];
        vgcs_pkg::CFG_BETA:  beta_q  <= cfg_data_i[vgcs_pkg::BETA_W-1:0];
        default: ;
      endcase
    end
  end

  assign vel        = {vel_z_i, vel_y_i, vel_x_i};
  assign in_stall_o = !in_ready;

  vgcs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .limit_i     (limit_q),
    .beta_i      (beta_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready),
    .vel_i       (vel),
    .out_valid_o (fr_valid),
    .out_ready_i (fr_ready),
    .out_o       (fr)
  );

  vgcs_weight u_weight (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (fr_valid),
    .in_ready_o  (fr_ready),
    .in_i        (fr),
    .out_valid_o (wt_valid),
    .out_ready_i (wt_ready),
    .out_o       (wt)
  );

  vgcs_emit #(
    .INDEX_BITS (INDEX_BITS)
  ) u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (wt_valid),
    .in_ready_o  (wt_ready),
    .in_i        (wt),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .grid_o      (grid),
    .weight_o    (weight_o),
    .status_o    (status),
    .last_o      (last_o)
  );

  assign grid_x_o = grid[0];
  assign grid_y_o = grid[1];
  assign grid_z_o = grid[2];
  assign status_o = status;

endmodule
